/* hw/rtl/input_capture_fifo_assert.svh */
// Assertion macros used by the capture FIFO checker.
`ifndef INPUT_CAPTURE_FIFO_ASSERT_SVH
`define INPUT_CAPTURE_FIFO_ASSERT_SVH

// Same-cycle implication.
`define ICF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("capture fifo assertion failed");

// Next-cycle implication.
`define ICF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("capture fifo assertion failed");

`endif

/* hw/rtl/icf_pkg.sv */
`default_nettype none
package icf_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int WORD_W    = 32;
   localparam int TIMER_W   = 16;
   localparam int MODE_W    = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_OFF,
      MODE_FIRST,
      MODE_SECOND,
      MODE_BOTH
   } mode_type;

endpackage
`default_nettype wire

/* hw/rtl/icf_ram.sv */
`default_nettype none
module icf_ram #(
   parameter int DEPTH = icf_pkg::DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  wire logic [icf_pkg::WORD_W-1:0]  wr_data,
   input  wire logic                        rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic      [icf_pkg::WORD_W-1:0]  rd_data
);

   logic [icf_pkg::WORD_W-1:0] mem [DEPTH];
   logic [icf_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/input_capture_fifo.sv */
// Capture timestamp FIFO: one item per cycle, busy is low except during reset.
// The result of an item is shown with strobe in the cycle after it is taken.
// Throughput: one item per clock; the buffer RAM takes one write and one read a cycle.
// Reset (synchronous) empties the buffer and sets timer_mode to off; RAM contents
// are left as they are. The receiver cannot stall, so results are never held.
`default_nettype none
module input_capture_fifo #(
   parameter int DEPTH = icf_pkg::DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_capture,
   input  wire logic [icf_pkg::TIMER_W-1:0]   req_timer_low_value,
   input  wire logic [icf_pkg::TIMER_W-1:0]   req_timer_high_value,
   input  wire logic                          req_pop_req,
   output logic                               strobe,
   output logic      [icf_pkg::WORD_W-1:0]    rsp_read_data,
   output logic                               rsp_read_valid,
   output logic                               rsp_not_empty,
   output logic                               rsp_full_res,
   input  wire logic                          csr_wr_en,
   input  wire logic [icf_pkg::MODE_W-1:0]    csr_wr_data
);

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   icf_pkg::mode_type timer_mode_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic          full_ff, full_in;

   logic          strobe_ff;
   logic          valid_ff;
   logic          not_empty_ff;
   logic          full_res_ff;
   logic          fwd_ff;
   logic [icf_pkg::WORD_W-1:0] fwd_data_ff;

   logic          accept;
   logic          push;
   logic          pop;
   logic          full_mid;
   logic          empty_mid;
   logic          fwd;
   logic [AW-1:0] tail_adv;
   logic [AW-1:0] head_adv;
   logic [icf_pkg::WORD_W-1:0] word;
   logic [icf_pkg::WORD_W-1:0] ram_rd_data;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      if (timer_mode_ff == icf_pkg::MODE_BOTH) begin
         word = {req_timer_high_value, req_timer_low_value};
      end else begin
         word = {{(icf_pkg::WORD_W - icf_pkg::TIMER_W){1'b0}}, req_timer_low_value};
      end
   end

   assign tail_adv = (tail_ff == LAST) ? '0 : tail_ff + AW'(1);
   assign head_adv = (head_ff == LAST) ? '0 : head_ff + AW'(1);

   assign push      = accept & req_capture & ~full_ff & (timer_mode_ff != icf_pkg::MODE_OFF);
   assign tail_in   = push ? tail_adv : tail_ff;
   assign full_mid  = push ? (head_ff == tail_adv) : full_ff;
   assign empty_mid = (head_ff == tail_in) & ~full_mid;
   assign pop       = accept & req_pop_req & ~empty_mid;
   assign head_in   = pop ? head_adv : head_ff;
   assign full_in   = pop ? 1'b0 : full_mid;
   // word written and popped in the same step: RAM read would see stale data
   assign fwd       = push & (head_ff == tail_ff);

   icf_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (word),
      .rd_en   (pop),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_mode_ff <= icf_pkg::MODE_OFF;
         head_ff       <= '0;
         tail_ff       <= '0;
         full_ff       <= 1'b0;
         strobe_ff     <= 1'b0;
         valid_ff      <= 1'b0;
         not_empty_ff  <= 1'b0;
         full_res_ff   <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timer_mode_ff <= icf_pkg::mode_type'(csr_wr_data);
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         full_ff      <= full_in;
         strobe_ff    <= accept;
         valid_ff     <= pop;
         not_empty_ff <= ~((head_in == tail_in) & ~full_in);
         full_res_ff  <= full_in;
         fwd_ff       <= fwd;
      end
      fwd_data_ff <= word;
   end

   assign strobe         = strobe_ff;
   assign rsp_read_valid = strobe_ff & valid_ff;
   assign rsp_not_empty  = not_empty_ff;
   assign rsp_full_res   = full_res_ff;

   always_comb begin
      if (!valid_ff) begin
         rsp_read_data = '0;
      end else if (fwd_ff) begin
         rsp_read_data = fwd_data_ff;
      end else begin
         rsp_read_data = ram_rd_data;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/icf_checker.sv */
`default_nettype none
`include "input_capture_fifo_assert.svh"
module icf_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        strobe,
   input wire logic [icf_pkg::WORD_W-1:0]  rsp_read_data,
   input wire logic                        rsp_read_valid,
   input wire logic                        rsp_not_empty,
   input wire logic                        rsp_full_res
);

   `ICF_ASSERT_NEXT(a_item_answered, clock, reset, start && !busy, strobe)
   `ICF_ASSERT_NEXT(a_no_spurious, clock, reset, !(start && !busy), !strobe)
   `ICF_ASSERT_NOW(a_idle_data_zero, clock, reset, strobe && !rsp_read_valid, rsp_read_data == '0)
   `ICF_ASSERT_NOW(a_full_not_empty, clock, reset, strobe && rsp_full_res, rsp_not_empty)
   `ICF_ASSERT_NOW(a_pop_clears_full, clock, reset, strobe && rsp_read_valid, !rsp_full_res)

endmodule

bind input_capture_fifo icf_checker u_icf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .strobe         (strobe),
   .rsp_read_data  (rsp_read_data),
   .rsp_read_valid (rsp_read_valid),
   .rsp_not_empty  (rsp_not_empty),
   .rsp_full_res   (rsp_full_res)
);
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

   localparam int DEPTH   = icf_pkg::DEPTH_DEF;
   localparam int IDLE_PC = 16;
   localparam int SETTLE  = 3;

   typedef enum {PK_ITEM, PK_MODE, PK_SYNC} pending_kind_type;

   typedef struct {
      pending_kind_type              kind;
      logic                          capture;
      logic [icf_pkg::TIMER_W-1:0]   t_low;
      logic [icf_pkg::TIMER_W-1:0]   t_high;
      logic                          pop;
      bit                            steady;
      icf_pkg::mode_type             mode;
   } pending_entry_type;

   typedef struct {
      logic [icf_pkg::WORD_W-1:0] data;
      logic                       valid;
      logic                       not_empty;
      logic                       full;
   } readout_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic                         req_capture = 1'b0;
   logic [icf_pkg::TIMER_W-1:0]  req_timer_low_value = '0;
   logic [icf_pkg::TIMER_W-1:0]  req_timer_high_value = '0;
   logic                         req_pop_req = 1'b0;
   logic                         strobe;
   logic [icf_pkg::WORD_W-1:0]   rsp_read_data;
   logic                         rsp_read_valid;
   logic                         rsp_not_empty;
   logic                         rsp_full_res;
   logic                         csr_wr_en = 1'b0;
   logic [icf_pkg::MODE_W-1:0]   csr_wr_data = '0;

   pending_entry_type pending_q[$];
   readout_type       expected_q[$];
   int                mismatches = 0;
   int                settle = 0;

   // capture buffer shadow
   logic [icf_pkg::WORD_W-1:0] stamp_mem[DEPTH];
   int                         head_pos = 0;
   int                         tail_pos = 0;
   bit                         is_full = 1'b0;
   icf_pkg::mode_type          cur_mode = icf_pkg::MODE_OFF;

   input_capture_fifo #(.DEPTH(DEPTH)) uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_capture          (req_capture),
      .req_timer_low_value  (req_timer_low_value),
      .req_timer_high_value (req_timer_high_value),
      .req_pop_req          (req_pop_req),
      .strobe               (strobe),
      .rsp_read_data        (rsp_read_data),
      .rsp_read_valid       (rsp_read_valid),
      .rsp_not_empty        (rsp_not_empty),
      .rsp_full_res         (rsp_full_res),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int next_pos(int pos);
      return (pos + 1 >= DEPTH) ? 0 : pos + 1;
   endfunction

   function automatic readout_type capture_and_read(logic cap, logic [15:0] lo,
                                                    logic [15:0] hi, logic pop);
      readout_type r;
      r.data  = '0;
      r.valid = 1'b0;
      if (cap && !is_full && cur_mode != icf_pkg::MODE_OFF) begin
         stamp_mem[tail_pos] = (cur_mode == icf_pkg::MODE_BOTH) ? {hi, lo} : {16'h0000, lo};
         tail_pos = next_pos(tail_pos);
         is_full = (head_pos == tail_pos);
      end
      if (pop && !(head_pos == tail_pos && !is_full)) begin
         r.data   = stamp_mem[head_pos];
         r.valid  = 1'b1;
         head_pos = next_pos(head_pos);
         is_full  = 1'b0;
      end
      r.not_empty = !(head_pos == tail_pos && !is_full);
      r.full      = is_full;
      return r;
   endfunction

   function automatic logic [15:0] rand_stamp();
      if ($urandom_range(0, 9) == 0)
         return {16{1'($urandom_range(0, 1))}};
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic add_item(logic cap, logic [15:0] lo, logic [15:0] hi, logic pop,
                           bit steady = 1'b0);
      pending_entry_type e;
      e.kind    = PK_ITEM;
      e.capture = cap;
      e.t_low   = lo;
      e.t_high  = hi;
      e.pop     = pop;
      e.steady  = steady;
      e.mode    = icf_pkg::MODE_OFF;
      pending_q.push_back(e);
   endtask

   task automatic add_mode(icf_pkg::mode_type m);
      pending_entry_type e;
      e = '{kind: PK_MODE, capture: 1'b0, t_low: '0, t_high: '0, pop: 1'b0, steady: 1'b0,
            mode: m};
      pending_q.push_back(e);
   endtask

   task automatic add_sync();
      pending_entry_type e;
      e = '{kind: PK_SYNC, capture: 1'b0, t_low: '0, t_high: '0, pop: 1'b0, steady: 1'b0,
            mode: icf_pkg::MODE_OFF};
      pending_q.push_back(e);
   endtask

   // driver
   always @(posedge clock) begin
      pending_entry_type e;
      logic              nxt_start;
      logic              nxt_wr;
      if (reset) begin
         start     <= 1'b0;
         csr_wr_en <= 1'b0;
         settle    <= 0;
      end else begin
         if (start && !busy)
            expected_q.push_back(capture_and_read(req_capture, req_timer_low_value,
                                                  req_timer_high_value, req_pop_req));
         if (!(start && busy)) begin
            nxt_start = 1'b0;
            nxt_wr    = 1'b0;
            if (pending_q.size() > 0) begin
               e = pending_q[0];
               if (e.kind == PK_ITEM) begin
                  if (e.steady || $urandom_range(0, 99) >= IDLE_PC) begin
                     nxt_start = 1'b1;
                     req_capture          <= e.capture;
                     req_timer_low_value  <= e.t_low;
                     req_timer_high_value <= e.t_high;
                     req_pop_req          <= e.pop;
                     void'(pending_q.pop_front());
                  end
               end else if (!start && !csr_wr_en && expected_q.size() == 0 &&
                            settle >= SETTLE) begin
                  if (e.kind == PK_MODE) begin
                     nxt_wr = 1'b1;
                     csr_wr_data <= e.mode;
                     cur_mode = e.mode;
                  end
                  void'(pending_q.pop_front());
               end
            end
            start     <= nxt_start;
            csr_wr_en <= nxt_wr;
         end
         if (!start && !csr_wr_en && expected_q.size() == 0)
            settle <= settle + 1;
         else
            settle <= 0;
      end
   end

   // monitor
   always @(posedge clock) begin
      readout_type want;
      if (!reset && strobe) begin
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected item: data=%h valid=%b not_empty=%b full=%b",
                        rsp_read_data, rsp_read_valid, rsp_not_empty, rsp_full_res);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_read_data !== want.data || rsp_read_valid !== want.valid ||
                rsp_not_empty !== want.not_empty || rsp_full_res !== want.full) begin
               if (mismatches < 10)
                  $display("mismatch: data %h/%h valid %b/%b not_empty %b/%b full %b/%b",
                           want.data, rsp_read_data, want.valid, rsp_read_valid,
                           want.not_empty, rsp_not_empty, want.full, rsp_full_res);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int cap_pc;
      int pop_pc;
      icf_pkg::mode_type m;

      // mode off after reset: captures dropped, pops on empty
      add_item(1'b1, 16'h1234, 16'h5678, 1'b0);
      add_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
      add_item(1'b0, 16'h0000, 16'h0000, 1'b1);
      // both timers packed, extremes, same-step capture and pop on empty
      add_mode(icf_pkg::MODE_BOTH);
      add_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
      add_item(1'b1, 16'h0000, 16'h0000, 1'b0);
      add_item(1'b0, 16'h0000, 16'h0000, 1'b1);
      add_item(1'b0, 16'h0000, 16'h0000, 1'b1);
      add_item(1'b0, 16'h0000, 16'h0000, 1'b1);
      add_item(1'b1, 16'hA5A5, 16'h5A5A, 1'b1);
      // fill to full, capture when full, capture and pop when full
      add_mode(icf_pkg::MODE_FIRST);
      for (int i = 0; i < DEPTH + 1; i++)
         add_item(1'b1, 16'(i * 4097), 16'hFFFF, 1'b0);
      add_item(1'b1, 16'hBEEF, 16'hDEAD, 1'b1);
      // off with words stored: pop still served
      add_mode(icf_pkg::MODE_OFF);
      add_item(1'b1, 16'h1111, 16'h2222, 1'b1);
      add_mode(icf_pkg::MODE_SECOND);
      add_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b1);

      for (int p = 0; p < 13; p++) begin
         m = (p < 4) ? icf_pkg::mode_type'((p + 3) % 4)
                     : icf_pkg::mode_type'($urandom_range(0, 3));
         add_mode(m);
         case (p % 3)
            0: begin cap_pc = 85; pop_pc = 15; end
            1: begin cap_pc = 20; pop_pc = 80; end
            default: begin cap_pc = 50; pop_pc = 50; end
         endcase
         for (int i = 0; i < 50; i++) begin
            if (p == 7 && i == 25)
               add_sync();
            add_item(1'($urandom_range(0, 99) < cap_pc), rand_stamp(), rand_stamp(),
                     1'($urandom_range(0, 99) < pop_pc), p == 5);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || start || expected_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (expected_q.size() != 0) begin
         if (mismatches < 10)
            $display("%0d expected items never arrived", expected_q.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("input_capture_fifo test passed");
      else
         $display("input_capture_fifo test failed");
      $finish;
   end

   initial begin
      #2ms;
      $display("input_capture_fifo test failed");
      $finish;
   end

endmodule
